### rtl/ekdc_pkg.sv
// shared types, codes and decode functions of the escape key decoder
`timescale 1ns / 1ps

package ekdc_pkg;

   // field widths on the ports
   localparam int BYTE_W     = 8;
   localparam int KEY_W      = 9;
   localparam int CURSOR_W   = 10;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 32;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // register indexes, taken from csr address bit 2
   localparam logic REG_SCREEN_ROWS = 1'b0;
   localparam logic REG_SCREEN_COLS = 1'b1;

   // input beat kinds
   localparam logic OP_BYTE    = 1'b0;
   localparam logic OP_TIMEOUT = 1'b1;

   // bytes of interest
   localparam logic [BYTE_W-1:0] CHAR_ESC     = 8'h1b;
   localparam logic [BYTE_W-1:0] CHAR_QUIT    = 8'h11;
   localparam logic [BYTE_W-1:0] CHAR_BRACKET = 8'h5b;
   localparam logic [BYTE_W-1:0] CHAR_O       = 8'h4f;
   localparam logic [BYTE_W-1:0] CHAR_TILDE   = 8'h7e;
   localparam logic [BYTE_W-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_ONE     = 8'h31;
   localparam logic [BYTE_W-1:0] CHAR_THREE   = 8'h33;
   localparam logic [BYTE_W-1:0] CHAR_FOUR    = 8'h34;
   localparam logic [BYTE_W-1:0] CHAR_FIVE    = 8'h35;
   localparam logic [BYTE_W-1:0] CHAR_SIX     = 8'h36;
   localparam logic [BYTE_W-1:0] CHAR_SEVEN   = 8'h37;
   localparam logic [BYTE_W-1:0] CHAR_EIGHT   = 8'h38;
   localparam logic [BYTE_W-1:0] CHAR_NINE    = 8'h39;
   localparam logic [BYTE_W-1:0] CHAR_A       = 8'h41;
   localparam logic [BYTE_W-1:0] CHAR_B       = 8'h42;
   localparam logic [BYTE_W-1:0] CHAR_C       = 8'h43;
   localparam logic [BYTE_W-1:0] CHAR_D       = 8'h44;
   localparam logic [BYTE_W-1:0] CHAR_F       = 8'h46;
   localparam logic [BYTE_W-1:0] CHAR_H       = 8'h48;

   // key codes
   localparam logic [KEY_W-1:0] KEY_ESC   = 9'h01b;
   localparam logic [KEY_W-1:0] KEY_QUIT  = 9'h011;
   localparam logic [KEY_W-1:0] KEY_LEFT  = 9'd256;
   localparam logic [KEY_W-1:0] KEY_RIGHT = 9'd257;
   localparam logic [KEY_W-1:0] KEY_UP    = 9'd258;
   localparam logic [KEY_W-1:0] KEY_DOWN  = 9'd259;
   localparam logic [KEY_W-1:0] KEY_DEL   = 9'd260;
   localparam logic [KEY_W-1:0] KEY_HOME  = 9'd261;
   localparam logic [KEY_W-1:0] KEY_END   = 9'd262;
   localparam logic [KEY_W-1:0] KEY_PGUP  = 9'd263;
   localparam logic [KEY_W-1:0] KEY_PGDN  = 9'd264;

   // parser phase
   typedef enum logic [3:0] {
      PH_IDLE  = 4'b0001,
      PH_ESC   = 4'b0010,
      PH_ESC_X = 4'b0100,
      PH_DIGIT = 4'b1000
   } phase_type;

   // key named by the digit of an ESC [ digit ~ sequence
   function automatic logic [KEY_W-1:0] decode_tilde(input logic [BYTE_W-1:0] digit);
      logic [KEY_W-1:0] key;
      case (digit)
         CHAR_ONE, CHAR_SEVEN:  key = KEY_HOME;
         CHAR_THREE:            key = KEY_DEL;
         CHAR_FOUR, CHAR_EIGHT: key = KEY_END;
         CHAR_FIVE:             key = KEY_PGUP;
         CHAR_SIX:              key = KEY_PGDN;
         default:               key = KEY_ESC;
      endcase
      return key;
   endfunction

   // key named by the two bytes after ESC
   function automatic logic [KEY_W-1:0] decode_pair(input logic [BYTE_W-1:0] a,
                                                    input logic [BYTE_W-1:0] b);
      logic [KEY_W-1:0] key;
      key = KEY_ESC;
      if (a == CHAR_BRACKET) begin
         case (b)
            CHAR_A:  key = KEY_UP;
            CHAR_B:  key = KEY_DOWN;
            CHAR_C:  key = KEY_RIGHT;
            CHAR_D:  key = KEY_LEFT;
            CHAR_H:  key = KEY_HOME;
            CHAR_F:  key = KEY_END;
            default: key = KEY_ESC;
         endcase
      end else if (a == CHAR_O) begin
         if (b == CHAR_H) key = KEY_HOME;
         else if (b == CHAR_F) key = KEY_END;
      end
      return key;
   endfunction

endpackage

### rtl/escape_key_decoder_cursor_core.sv
// escape sequence key decoder with a cursor held inside the screen
//
//   port group | direction | beat contents
//   req_*      | in        | tdata: in_byte[7:0]; tuser: op (1 = read timeout)
//   rsp_*      | out       | tdata: key_code[8:0], cursor_col[18:9], cursor_row[28:19]
//              |           | tuser: quit
//   csr_*      | in/out    | apb registers screen_rows at 0x0, screen_cols at 0x4
//
// one beat per cycle in and out while the result side does not stall; a result passes
// the input register, then the result register; parser and cursor state feed back, so
// each beat sees the state of the last; beats that only advance the parser give no result
// reset: parser idle, cursor at 0/0, screen 24 rows by 80 columns
// a stalled result holds while the next input beat moves into the input register
`timescale 1ns / 1ps

module escape_key_decoder_cursor_core #(
   parameter int DIM_BITS = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   // input beats
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [ekdc_pkg::REQ_DATA_W-1:0]   req_tdata,   // [7:0] in_byte
   input  logic                              req_tuser,   // [0] op
   // result beats
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ekdc_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // [8:0] key_code, [18:9] cursor_col,
                                                          // [28:19] cursor_row, [31:29] zero
   output logic                              rsp_tuser,   // [0] quit
   // configuration
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [ekdc_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [ekdc_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [ekdc_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import ekdc_pkg::*;

   localparam logic [DIM_BITS-1:0] ROWS_RESET = DIM_BITS'(24);
   localparam logic [DIM_BITS-1:0] COLS_RESET = DIM_BITS'(80);

   // configuration registers
   logic [DIM_BITS-1:0] screen_rows_ff, screen_rows_in;
   logic [DIM_BITS-1:0] screen_cols_ff, screen_cols_in;
   logic                csr_write;

   // input register
   logic                s1_valid_ff, s1_valid_in;
   logic                s1_op_ff;
   logic [BYTE_W-1:0]   s1_byte_ff;
   logic                advance;

   // parser and cursor state
   phase_type           phase_ff, phase_in;
   logic [BYTE_W-1:0]   first_seq_ff, first_seq_in;
   logic [BYTE_W-1:0]   second_seq_ff, second_seq_in;
   logic [DIM_BITS-1:0] col_ff, col_in;
   logic [DIM_BITS-1:0] row_ff, row_in;

   // decode results
   logic                has_result;
   logic [KEY_W-1:0]    key;
   logic [DIM_BITS-1:0] max_row, max_col;
   logic [DIM_BITS-1:0] row_clamp, col_clamp;
   logic [DIM_BITS-1:0] row_next, col_next;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [KEY_W-1:0]    rsp_key_ff;
   logic [CURSOR_W-1:0] rsp_col_ff;
   logic [CURSOR_W-1:0] rsp_row_ff;
   logic                rsp_quit_ff;

   // apb register writes and reads
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      screen_rows_in = screen_rows_ff;
      screen_cols_in = screen_cols_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            REG_SCREEN_ROWS: screen_rows_in = csr_pwdata[DIM_BITS-1:0];
            REG_SCREEN_COLS: screen_cols_in = csr_pwdata[DIM_BITS-1:0];
            default:         screen_rows_in = screen_rows_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_SCREEN_ROWS: csr_prdata = CSR_DATA_W'(screen_rows_ff);
         REG_SCREEN_COLS: csr_prdata = CSR_DATA_W'(screen_cols_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // the input register moves on whenever the result register can take its beat
   assign advance     = s1_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready  = ~s1_valid_ff | advance;
   assign s1_valid_in = req_tready ? req_tvalid : s1_valid_ff;

   // parser: one byte or timeout per beat
   always_comb begin
      phase_in      = phase_ff;
      first_seq_in  = first_seq_ff;
      second_seq_in = second_seq_ff;
      has_result    = 1'b0;
      key           = KEY_ESC;
      if (s1_op_ff == OP_TIMEOUT) begin
         if (phase_ff != PH_IDLE) begin
            phase_in   = PH_IDLE;
            has_result = 1'b1;
            key        = KEY_ESC;
         end
      end else begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (s1_byte_ff == CHAR_ESC) begin
                  phase_in = PH_ESC;
               end else begin
                  has_result = 1'b1;
                  key        = KEY_W'(s1_byte_ff);
               end
            end
            PH_ESC: begin
               first_seq_in = s1_byte_ff;
               phase_in     = PH_ESC_X;
            end
            PH_ESC_X: begin
               second_seq_in = s1_byte_ff;
               if (first_seq_ff == CHAR_BRACKET && s1_byte_ff >= CHAR_ZERO
                   && s1_byte_ff <= CHAR_NINE) begin
                  phase_in = PH_DIGIT;
               end else begin
                  phase_in   = PH_IDLE;
                  has_result = 1'b1;
                  key        = decode_pair(first_seq_ff, s1_byte_ff);
               end
            end
            PH_DIGIT: begin
               phase_in   = PH_IDLE;
               has_result = 1'b1;
               key        = (s1_byte_ff == CHAR_TILDE) ? decode_tilde(second_seq_ff)
                                                       : KEY_ESC;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   // cursor: clamp to the current screen, then apply the key
   assign max_row   = (screen_rows_ff == '0) ? '0 : screen_rows_ff - 1'b1;
   assign max_col   = (screen_cols_ff == '0) ? '0 : screen_cols_ff - 1'b1;
   assign row_clamp = (row_ff > max_row) ? max_row : row_ff;
   assign col_clamp = (col_ff > max_col) ? max_col : col_ff;

   always_comb begin
      row_next = row_clamp;
      col_next = col_clamp;
      case (key)
         KEY_LEFT:  if (col_clamp != '0) col_next = col_clamp - 1'b1;
         KEY_RIGHT: if (col_clamp != max_col) col_next = col_clamp + 1'b1;
         KEY_UP:    if (row_clamp != '0) row_next = row_clamp - 1'b1;
         KEY_DOWN:  if (row_clamp != max_row) row_next = row_clamp + 1'b1;
         KEY_HOME:  col_next = '0;
         KEY_END:   col_next = max_col;
         KEY_PGUP:  row_next = '0;
         KEY_PGDN:  row_next = max_row;
         default:   ;
      endcase
   end

   assign row_in = (advance && has_result) ? row_next : row_ff;
   assign col_in = (advance && has_result) ? col_next : col_ff;

   // result register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) rsp_valid_in = has_result;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         screen_rows_ff <= ROWS_RESET;
         screen_cols_ff <= COLS_RESET;
         s1_valid_ff    <= 1'b0;
         phase_ff       <= PH_IDLE;
         col_ff         <= '0;
         row_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         screen_rows_ff <= screen_rows_in;
         screen_cols_ff <= screen_cols_in;
         s1_valid_ff    <= s1_valid_in;
         if (advance) phase_ff <= phase_in;
         col_ff         <= col_in;
         row_ff         <= row_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_op_ff   <= req_tuser;
         s1_byte_ff <= req_tdata[BYTE_W-1:0];
      end
      if (advance) begin
         first_seq_ff  <= first_seq_in;
         second_seq_ff <= second_seq_in;
      end
      if (advance && has_result) begin
         rsp_key_ff  <= key;
         rsp_col_ff  <= CURSOR_W'(col_next);
         rsp_row_ff  <= CURSOR_W'(row_next);
         rsp_quit_ff <= (key == KEY_QUIT);
      end
   end

   // result beat
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_row_ff, rsp_col_ff, rsp_key_ff});
   assign rsp_tuser  = rsp_quit_ff;

endmodule

### rtl/ekdc_checker.sv
// port-level checks of the escape key decoder, bound to the top level
`timescale 1ns / 1ps

module ekdc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [ekdc_pkg::REQ_DATA_W-1:0]   req_tdata,
   input logic                              req_tuser,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [ekdc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input logic                              rsp_tuser,
   input logic                              csr_psel,
   input logic                              csr_penable,
   input logic                              csr_pwrite,
   input logic [ekdc_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input logic [ekdc_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   input logic [ekdc_pkg::CSR_DATA_W-1:0]   csr_prdata,
   input logic                              csr_pready
);
   import ekdc_pkg::*;

   // quit flag only on the ctrl-q key
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == (rsp_tdata[KEY_W-1:0] == KEY_QUIT)))
      else $error("quit flag does not match key code");

   // no key code beyond page down
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[KEY_W-1:0] <= KEY_PGDN))
      else $error("key code out of range");

   // no result beat straight after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result beat right after reset");

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result beat changed");

endmodule

bind escape_key_decoder_cursor_core ekdc_checker u_ekdc_checker (.*);
